>>> src/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
`timescale 1ns / 1ps

package mpct_pkg;

   // Field widths fixed by the interface
   localparam int DATA_BITS   = 8;
   localparam int SIZE_BITS   = 13;
   localparam int CURSOR_BITS = 12;
   localparam int CSR_INDEX_BITS = 2;

   // Default coordinate register width
   localparam int COORD_BITS_DEFAULT = 12;

   // Queue depths between the stages
   localparam int PKT_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Screen size reset values
   localparam logic [SIZE_BITS-1:0] COLUMNS_RESET = 13'd640;
   localparam logic [SIZE_BITS-1:0] ROWS_RESET    = 13'd480;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS    = 2'd1;

   // Complete mouse packet handed from front to back
   typedef struct packed {
      logic                 left_button;
      logic [DATA_BITS-1:0] delta_x;
      logic [DATA_BITS-1:0] delta_y;
   } packet_type;

   // Result transaction
   typedef struct packed {
      logic [CURSOR_BITS-1:0] cursor_x;
      logic [CURSOR_BITS-1:0] cursor_y;
      logic                   left_button;
   } rsp_type;

endpackage

>>> src/mouse_packet_cursor_tracker.sv
// Top level of the mouse packet cursor tracker.
`timescale 1ns / 1ps

// Usage:
//   Input queue side: drive req_data_byte/req_from_aux and raise req_push; a
//   byte is taken at each edge with req_push high and req_full low. Bytes with
//   req_from_aux low (keyboard) are dropped. Every third mouse byte completes a
//   packet, which yields one transaction on the result side.
//   Result queue side: while rsp_empty is low the oldest cursor position and
//   button are on rsp_*; raise rsp_pop to take it.
//   CSR side: csr_ready is always high; index 0 sets screen width, 1 screen
//   height. Other indexes are ignored. New sizes apply at the next packet.
//   Throughput: one byte per cycle while req_full is low. The edge that takes
//   the third byte writes the packet queue; the cursor stage moves the packet
//   into the result queue when that has room, and the result is then on rsp_*.
//   Stall: when the result queue fills, the cursor stage stops, the two-entry
//   packet queue fills and req_full rises; nothing is lost.
//   Reset: sizes return to 640 x 480, the cursor is centered, the packet byte
//   position returns to the header byte and both queues empty.
module mouse_packet_cursor_tracker
   import mpct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [DATA_BITS-1:0]      req_data_byte,
   input  logic                      req_from_aux,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [CURSOR_BITS-1:0]    rsp_cursor_x,
   output logic [CURSOR_BITS-1:0]    rsp_cursor_y,
   output logic                      rsp_left_button,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS-1:0]      csr_wdata
);

   logic [SIZE_BITS-1:0] num_columns_ff, num_columns_in;
   logic [SIZE_BITS-1:0] num_rows_ff, num_rows_in;

   logic       front_push;
   packet_type front_pkt;
   logic       pkt_full, pkt_empty, pkt_pop;
   packet_type pkt_head;
   logic       back_push;
   rsp_type    back_rsp;
   logic       rsp_q_full;
   rsp_type    rsp_head;
   logic       rsp_take;

   // Decode CSR writes
   assign csr_ready = 1'b1;

   always_comb begin
      num_columns_in = num_columns_ff;
      num_rows_in    = num_rows_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMNS: num_columns_in = csr_wdata;
            CSR_ROWS:    num_rows_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff <= COLUMNS_RESET;
         num_rows_ff    <= ROWS_RESET;
      end else begin
         num_columns_ff <= num_columns_in;
         num_rows_ff    <= num_rows_in;
      end
   end

   mpct_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_from_aux  (req_from_aux),
      .req_full      (req_full),
      .pkt_push      (front_push),
      .pkt_data      (front_pkt),
      .pkt_full      (pkt_full)
   );

   mpct_fifo #(
      .WIDTH ($bits(packet_type)),
      .DEPTH (PKT_QUEUE_DEPTH)
   ) u_pkt_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_pkt),
      .full  (pkt_full),
      .pop   (pkt_pop),
      .rdata (pkt_head),
      .empty (pkt_empty)
   );

   mpct_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .num_columns (num_columns_ff),
      .num_rows    (num_rows_ff),
      .pkt_empty   (pkt_empty),
      .pkt_data    (pkt_head),
      .pkt_pop     (pkt_pop),
      .rsp_push    (back_push),
      .rsp_data    (back_rsp),
      .rsp_full    (rsp_q_full)
   );

   // Pop the result queue only on a completed transaction
   assign rsp_take = rsp_pop && !rsp_empty;

   mpct_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (back_push),
      .wdata (back_rsp),
      .full  (rsp_q_full),
      .pop   (rsp_take),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_cursor_x    = rsp_head.cursor_x;
   assign rsp_cursor_y    = rsp_head.cursor_y;
   assign rsp_left_button = rsp_head.left_button;

endmodule

>>> src/mpct_fifo.sv
// Small register-based queue with push/full and pop/empty sides.
`timescale 1ns / 1ps

module mpct_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == DEPTH_CNT);
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("queue occupancy out of range");

endmodule

>>> src/mpct_front.sv
// Front stage: filters keyboard bytes and assembles three-byte mouse packets.
`timescale 1ns / 1ps

module mpct_front
   import mpct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [DATA_BITS-1:0] req_data_byte,
   input  logic                 req_from_aux,
   output logic                 req_full,
   output logic                 pkt_push,
   output packet_type           pkt_data,
   input  logic                 pkt_full
);

   typedef enum logic [2:0] {
      ST_BYTE0 = 3'b001,
      ST_BYTE1 = 3'b010,
      ST_BYTE2 = 3'b100
   } byte_state_type;

   byte_state_type       state_ff, state_in;
   logic [DATA_BITS-1:0] header_ff, header_in;
   logic [DATA_BITS-1:0] delta_x_ff, delta_x_in;
   logic                 accept;
   logic                 mouse_byte;

   // Stall input only when the packet queue cannot take a packet
   assign req_full   = pkt_full;
   assign accept     = req_push && !req_full;
   assign mouse_byte = accept && req_from_aux;

   // Gather packet bytes; drop keyboard bytes
   always_comb begin
      state_in   = state_ff;
      header_in  = header_ff;
      delta_x_in = delta_x_ff;
      pkt_push   = 1'b0;
      if (mouse_byte) begin
         unique case (state_ff)
            ST_BYTE0: begin
               header_in = req_data_byte;
               state_in  = ST_BYTE1;
            end
            ST_BYTE1: begin
               delta_x_in = req_data_byte;
               state_in   = ST_BYTE2;
            end
            ST_BYTE2: begin
               pkt_push = 1'b1;
               state_in = ST_BYTE0;
            end
            default: begin
               state_in = ST_BYTE0;
            end
         endcase
      end
   end

   assign pkt_data.left_button = header_ff[0];
   assign pkt_data.delta_x     = delta_x_ff;
   assign pkt_data.delta_y     = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_BYTE0;
         header_ff  <= '0;
         delta_x_ff <= '0;
      end else begin
         state_ff   <= state_in;
         header_ff  <= header_in;
         delta_x_ff <= delta_x_in;
      end
   end

   a_kbd_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_from_aux) |=> $stable(state_ff))
      else $error("keyboard byte moved the packet position");
   a_packet_wraps: assert property (@(posedge clock) disable iff (reset)
      (mouse_byte && state_ff == ST_BYTE2) |=> (state_ff == ST_BYTE0))
      else $error("packet position did not wrap after third byte");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      !(pkt_push && pkt_full))
      else $error("packet pushed into full queue");

endmodule

>>> src/mpct_back.sv
// Back stage: applies packet deltas to the cursor and clamps it to the screen.
`timescale 1ns / 1ps

module mpct_back
   import mpct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SIZE_BITS-1:0] num_columns,
   input  logic [SIZE_BITS-1:0] num_rows,
   input  logic                 pkt_empty,
   input  packet_type           pkt_data,
   output logic                 pkt_pop,
   output logic                 rsp_push,
   output rsp_type              rsp_data,
   input  logic                 rsp_full
);

   localparam int EW = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
   localparam int SW = COORD_BITS + 2;
   localparam logic [EW-1:0] LIMIT = EW'(1) << COORD_BITS;

   // Effective size: zero acts as one, large values saturate at the coordinate range
   function automatic logic [EW-1:0] eff_size(input logic [SIZE_BITS-1:0] sz);
      logic [EW-1:0] s;
      s = EW'(sz);
      if (s == '0) begin
         s = EW'(1);
      end
      if (s > LIMIT) begin
         s = LIMIT;
      end
      return s;
   endfunction

   // Clamp a signed sum into [0, max]
   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                   input logic [COORD_BITS-1:0] max);
      logic [COORD_BITS-1:0] r;
      if (v[SW-1]) begin
         r = '0;
      end else if (v[COORD_BITS:0] > {1'b0, max}) begin
         r = max;
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   localparam logic [COORD_BITS-1:0] X_HOME = COORD_BITS'(eff_size(COLUMNS_RESET) >> 1);
   localparam logic [COORD_BITS-1:0] Y_HOME = COORD_BITS'(eff_size(ROWS_RESET) >> 1);

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0] max_x, max_y;
   logic signed [SW-1:0]  sum_x, sum_y;

   // Consume a packet whenever the result queue has room
   assign pkt_pop  = !pkt_empty && !rsp_full;
   assign rsp_push = pkt_pop;

   assign max_x = COORD_BITS'(eff_size(num_columns) - EW'(1));
   assign max_y = COORD_BITS'(eff_size(num_rows) - EW'(1));

   // X moves by the delta, Y by the negated delta (down positive)
   assign sum_x = $signed({2'b00, pos_x_ff})
                + $signed({{(SW - DATA_BITS){pkt_data.delta_x[DATA_BITS-1]}}, pkt_data.delta_x});
   assign sum_y = $signed({2'b00, pos_y_ff})
                - $signed({{(SW - DATA_BITS){pkt_data.delta_y[DATA_BITS-1]}}, pkt_data.delta_y});

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (pkt_pop) begin
         pos_x_in = clamp(sum_x, max_x);
         pos_y_in = clamp(sum_y, max_y);
      end
   end

   assign rsp_data.cursor_x    = CURSOR_BITS'(pos_x_in);
   assign rsp_data.cursor_y    = CURSOR_BITS'(pos_y_in);
   assign rsp_data.left_button = pkt_data.left_button;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= X_HOME;
         pos_y_ff <= Y_HOME;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   a_x_in_screen: assert property (@(posedge clock) disable iff (reset)
      pkt_pop |=> (pos_x_ff <= $past(max_x)))
      else $error("cursor X beyond screen width");
   a_y_in_screen: assert property (@(posedge clock) disable iff (reset)
      pkt_pop |=> (pos_y_ff <= $past(max_y)))
      else $error("cursor Y beyond screen height");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !pkt_pop |=> ($stable(pos_x_ff) && $stable(pos_y_ff)))
      else $error("cursor moved without a packet");

endmodule

>>> sim/mpct_checker.sv
// Checker for the mouse packet cursor tracker: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module mpct_checker
   import mpct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_full,
   input  logic [DATA_BITS-1:0]      req_data_byte,
   input  logic                      req_from_aux,
   input  logic                      rsp_empty,
   input  logic                      rsp_pop,
   input  logic [CURSOR_BITS-1:0]    rsp_cursor_x,
   input  logic [CURSOR_BITS-1:0]    rsp_cursor_y,
   input  logic                      rsp_left_button,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS-1:0]      csr_wdata,
   output int                        mismatch_count,
   output int                        expected_count
);

   localparam int COORD_LIMIT = 1 << COORD_BITS;

   // Which byte of a mouse packet comes next
   typedef enum logic [2:0] {
      AT_HEADER  = 3'b001,
      AT_DELTA_X = 3'b010,
      AT_DELTA_Y = 3'b100
   } packet_slot_type;

   logic [SIZE_BITS-1:0] width_reg;
   logic [SIZE_BITS-1:0] height_reg;
   packet_slot_type      slot;
   logic [DATA_BITS-1:0] header_q;
   logic [DATA_BITS-1:0] delta_x_q;
   int                   cursor_x;
   int                   cursor_y;
   rsp_type              cursor_q[$];
   rsp_type              predicted;
   rsp_type              observed;
   int                   errors = 0;

   // Size register as the clamp sees it: zero acts as one, oversize saturates
   function automatic int usable_size(input logic [SIZE_BITS-1:0] size_value);
      int s;
      s = int'(size_value);
      if (s < 1) s = 1;
      if (s > COORD_LIMIT) s = COORD_LIMIT;
      return s;
   endfunction

   function automatic int clamp_coord(input int v, input int size);
      if (v < 0) return 0;
      if (v >= size) return size - 1;
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         // Restore sizes, then center the cursor on them
         width_reg  = COLUMNS_RESET;
         height_reg = ROWS_RESET;
         slot       = AT_HEADER;
         header_q   = '0;
         delta_x_q  = '0;
         cursor_x   = usable_size(COLUMNS_RESET) / 2;
         cursor_y   = usable_size(ROWS_RESET) / 2;
         cursor_q.delete();
      end else begin
         // Apply register writes; unmapped indexes are dropped
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COLUMNS) width_reg = csr_wdata;
            else if (csr_index == CSR_ROWS) height_reg = csr_wdata;
         end

         // Compare each result transaction with the oldest predicted cursor
         if (rsp_pop && !rsp_empty) begin
            observed.cursor_x    = rsp_cursor_x;
            observed.cursor_y    = rsp_cursor_y;
            observed.left_button = rsp_left_button;
            if (cursor_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result x=%0d y=%0d button=%0b", $time,
                        observed.cursor_x, observed.cursor_y, observed.left_button);
            end else begin
               predicted = cursor_q.pop_front();
               if (observed.cursor_x !== predicted.cursor_x) begin
                  errors++;
                  $display("%0t: cursor_x expected %0d actual %0d", $time,
                           predicted.cursor_x, observed.cursor_x);
               end
               if (observed.cursor_y !== predicted.cursor_y) begin
                  errors++;
                  $display("%0t: cursor_y expected %0d actual %0d", $time,
                           predicted.cursor_y, observed.cursor_y);
               end
               if (observed.left_button !== predicted.left_button) begin
                  errors++;
                  $display("%0t: left_button expected %0b actual %0b", $time,
                           predicted.left_button, observed.left_button);
               end
            end
         end

         // Track accepted mouse bytes; keyboard bytes change nothing
         if (req_push && !req_full && req_from_aux) begin
            case (slot)
               AT_HEADER: begin
                  header_q = req_data_byte;
                  slot     = AT_DELTA_X;
               end
               AT_DELTA_X: begin
                  delta_x_q = req_data_byte;
                  slot      = AT_DELTA_Y;
               end
               default: begin
                  // Packet complete: move, clamp, and predict one result
                  cursor_x = clamp_coord(cursor_x + int'($signed(delta_x_q)),
                                         usable_size(width_reg));
                  cursor_y = clamp_coord(cursor_y - int'($signed(req_data_byte)),
                                         usable_size(height_reg));
                  predicted.cursor_x    = cursor_x[CURSOR_BITS-1:0];
                  predicted.cursor_y    = cursor_y[CURSOR_BITS-1:0];
                  predicted.left_button = header_q[0];
                  cursor_q.push_back(predicted);
                  slot = AT_HEADER;
               end
            endcase
         end
      end

      mismatch_count <= errors;
      expected_count <= cursor_q.size();
   end

endmodule

>>> sim/mouse_packet_cursor_tracker_tb.sv
// Testbench top for the mouse packet cursor tracker: stimulus, idling and verdict.
`timescale 1ns / 1ps

module mouse_packet_cursor_tracker_tb
   import mpct_pkg::*;
();

   localparam logic FROM_MOUSE    = 1'b1;
   localparam logic FROM_KEYBOARD = 1'b0;

   // Indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 2'd3;

   localparam int MOUSE_BYTES_PER_PHASE = 146;
   localparam int SETTLE_CYCLES         = 6;
   localparam int RX_HOLD_CYCLES        = 400;
   localparam int TIMEOUT_NS            = 4_000_000;

   logic                      clock;
   logic                      reset           = 1'b1;
   logic                      req_push        = 1'b0;
   logic                      req_full;
   logic [DATA_BITS-1:0]      req_data_byte   = '0;
   logic                      req_from_aux    = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop         = 1'b0;
   logic [CURSOR_BITS-1:0]    rsp_cursor_x;
   logic [CURSOR_BITS-1:0]    rsp_cursor_y;
   logic                      rsp_left_button;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index       = '0;
   logic [SIZE_BITS-1:0]      csr_wdata       = '0;

   int mismatch_count;
   int expected_count;
   int tx_idle_pct   = 30;
   int rx_idle_pct   = 30;
   int hold_request  = 0;
   int hold_served   = 0;

   mouse_packet_cursor_tracker u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_from_aux    (req_from_aux),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cursor_x    (rsp_cursor_x),
      .rsp_cursor_y    (rsp_cursor_y),
      .rsp_left_button (rsp_left_button),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   mpct_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_from_aux    (req_from_aux),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cursor_x    (rsp_cursor_x),
      .rsp_cursor_y    (rsp_cursor_y),
      .rsp_left_button (rsp_left_button),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .expected_count  (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random pops, with a long hold-off whenever one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_served != hold_request) begin
            rsp_pop <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("mouse_packet_cursor_tracker_tb failed");
      $finish;
   end

   // Offer one byte, idling at random first, and hold it until accepted
   task automatic push_byte(input logic [DATA_BITS-1:0] data, input logic aux);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= data;
      req_from_aux  <= aux;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Mouse byte, sometimes with a keyboard byte slipped in ahead of it
   task automatic push_mouse(input logic [DATA_BITS-1:0] data);
      if ($urandom_range(0, 99) < 10) push_byte(DATA_BITS'($urandom), FROM_KEYBOARD);
      push_byte(data, FROM_MOUSE);
   endtask

   // Stop offering and wait until every predicted cursor has come out
   task automatic drain_block();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so that writes can follow back to back
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [SIZE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_screen(input logic [SIZE_BITS-1:0] width,
                             input logic [SIZE_BITS-1:0] height);
      write_csr(CSR_COLUMNS, width);
      write_csr(CSR_ROWS, height);
      if ($urandom_range(0, 1))
         write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                   SIZE_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Random delta, or one leaning in the drift direction to reach the edges
   function automatic logic [DATA_BITS-1:0] delta_byte(input int drift);
      int v;
      if (drift == 0 || $urandom_range(0, 2) == 0) return DATA_BITS'($urandom);
      v = $urandom_range(32, 127);
      if (drift < 0) v = 256 - v - 1;
      return v[DATA_BITS-1:0];
   endfunction

   task automatic run_phase(input logic [SIZE_BITS-1:0] width,
                            input logic [SIZE_BITS-1:0] height,
                            input int drift_x, input int drift_y,
                            input int tx_idle, input int rx_idle, input bit hold_off);
      int mouse_bytes;
      mouse_bytes = 0;
      drain_block();
      set_screen(width, height);
      tx_idle_pct = tx_idle;
      rx_idle_pct = rx_idle;
      if (hold_off) hold_request <= hold_request + 1;
      while (mouse_bytes < MOUSE_BYTES_PER_PHASE) begin
         if ($urandom_range(0, 99) < 15) begin
            // Noise: a stray mouse byte breaks the packet framing
            if ($urandom_range(0, 1)) begin
               push_byte(DATA_BITS'($urandom), FROM_MOUSE);
               mouse_bytes++;
            end else begin
               push_byte(DATA_BITS'($urandom), FROM_KEYBOARD);
            end
         end else begin
            // Well-formed packet; Y moves down for a negative byte
            push_mouse(DATA_BITS'($urandom));
            push_mouse(delta_byte(drift_x));
            push_mouse(delta_byte(-drift_y));
            mouse_bytes += 3;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored keyboard byte, full-scale deltas, keyboard bytes mid-packet
      push_byte(8'hFF, FROM_KEYBOARD);
      push_byte(8'h09, FROM_MOUSE);
      push_byte(8'h7F, FROM_MOUSE);
      push_byte(8'h80, FROM_MOUSE);
      push_byte(8'h08, FROM_MOUSE);
      push_byte(8'h00, FROM_KEYBOARD);
      push_byte(8'h80, FROM_MOUSE);
      push_byte(8'hAA, FROM_KEYBOARD);
      push_byte(8'h7F, FROM_MOUSE);
      // Header with overflow and sign bits set that must be ignored
      push_byte(8'hFF, FROM_MOUSE);
      push_byte(8'h00, FROM_MOUSE);
      push_byte(8'h00, FROM_MOUSE);
      push_byte(8'h00, FROM_MOUSE);
      push_byte(8'h01, FROM_MOUSE);
      push_byte(8'hFF, FROM_MOUSE);
      push_byte(8'h20, FROM_MOUSE);
      push_byte(8'h60, FROM_MOUSE);
      push_byte(8'h64, FROM_MOUSE);
      // Partial packet left open across the first size change
      push_byte(8'h01, FROM_MOUSE);

      // Size zero, size one, oversize, exact limit and just past it
      run_phase(13'd0, 13'd0, 0, 0, 30, 30, 1'b0);
      run_phase(13'd1, 13'd1, 1, -1, 30, 30, 1'b0);
      run_phase(13'd8191, 13'd8191, 1, 1, 30, 30, 1'b0);
      run_phase(13'd4096, 13'd4097, -1, -1, 30, 30, 1'b0);
      run_phase(13'd4097, 13'd4096, 1, -1, 30, 30, 1'b0);
      run_phase(SIZE_BITS'($urandom_range(2, 40)), SIZE_BITS'($urandom_range(2, 40)),
                0, 0, 30, 30, 1'b0);
      // Receiver holds off while the sender keeps offering
      run_phase(SIZE_BITS'($urandom_range(0, 8191)), SIZE_BITS'($urandom_range(0, 8191)),
                0, 0, 0, 30, 1'b1);
      // Phase with no idling on either side
      run_phase(COLUMNS_RESET, ROWS_RESET, 0, 0, 0, 0, 1'b0);
      run_phase(SIZE_BITS'($urandom_range(0, 8191)), SIZE_BITS'($urandom_range(0, 8191)),
                $urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1, 30, 30, 1'b0);
      run_phase(13'd3, 13'd8191, -1, 1, 30, 30, 1'b0);

      drain_block();
      if (mismatch_count == 0 && expected_count == 0) begin
         $display("mouse_packet_cursor_tracker_tb passed");
      end else begin
         $display("mouse_packet_cursor_tracker_tb failed");
      end
      $finish;
   end

endmodule
